/* rtl/bsp_pkg.sv */
package bsp_pkg;

   localparam int ROW_WIDTH = 8;
   localparam int PIX_W     = 8;
   localparam int PHASE_W   = 3;
   localparam int ROWS_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ROWS = 2'd2;

   localparam logic [ROWS_W-1:0] BLOCK_ROWS_RESET = 4'd8;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [ROW_WIDTH-1:0] row_type;

   typedef struct packed {
      pixel_type pix0;
      pixel_type pix1;
      pixel_type pix2;
      pixel_type pix3;
      pixel_type pix4;
      pixel_type pix5;
      pixel_type pix6;
      pixel_type pix7;
      pixel_type pix8;
   } req_type;

   typedef struct packed {
      pixel_type out0;
      pixel_type out1;
      pixel_type out2;
      pixel_type out3;
      pixel_type out4;
      pixel_type out5;
      pixel_type out6;
      pixel_type out7;
      logic      last_row;
   } rsp_type;

   // control carried from the horizontal stage to the vertical stage
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } ctl_type;

   // two-tap filter; taps 128-16p and 16p reduce to 8-p and p with a shift of 3
   function automatic pixel_type tap2(input pixel_type a, input pixel_type b,
                                      input logic [PHASE_W-1:0] phase);
      logic [3:0]  w1;
      logic [3:0]  w0;
      logic [11:0] acc;
      w1  = {1'b0, phase};
      w0  = 4'd8 - w1;
      acc = {4'b0, a} * {8'b0, w0} + {4'b0, b} * {8'b0, w1} + 12'd4;
      return acc[10:3];
   endfunction

endpackage

/* rtl/bsp_hstage.sv */
module bsp_hstage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bsp_pkg::req_type               req_payload,
   input  logic [bsp_pkg::PHASE_W-1:0]    x_offset,
   input  logic [bsp_pkg::ROWS_W-1:0]     block_rows,
   input  logic                           advance,
   output bsp_pkg::ctl_type               ctl,
   output bsp_pkg::row_type               hrow
);

   bsp_pkg::ctl_type                  ctl_ff, ctl_in;
   bsp_pkg::row_type                  hrow_ff, hrow_in;
   logic [bsp_pkg::ROWS_W-1:0]        count_ff, count_in;
   logic [bsp_pkg::ROWS_W-1:0]        rows;
   bsp_pkg::pixel_type [bsp_pkg::ROW_WIDTH:0] src;
   logic                              take;

   assign src[0] = req_payload.pix0;
   assign src[1] = req_payload.pix1;
   assign src[2] = req_payload.pix2;
   assign src[3] = req_payload.pix3;
   assign src[4] = req_payload.pix4;
   assign src[5] = req_payload.pix5;
   assign src[6] = req_payload.pix6;
   assign src[7] = req_payload.pix7;
   assign src[8] = req_payload.pix8;

   assign req_ready = !ctl_ff.valid || advance;
   assign take      = req_valid && req_ready;
   assign rows      = (block_rows == '0) ? 4'd1 : block_rows;

   always_comb begin
      for (int i = 0; i < bsp_pkg::ROW_WIDTH; i++) begin
         hrow_in[i] = bsp_pkg::tap2(src[i], src[i+1], x_offset);
      end
   end

   always_comb begin
      ctl_in   = ctl_ff;
      count_in = count_ff;
      if (take) begin
         ctl_in.valid = 1'b1;
         ctl_in.first = 1'b0;
         ctl_in.last  = 1'b0;
         if (count_ff == '0) begin
            ctl_in.first = 1'b1;
            count_in     = 4'd1;
         end else if (count_ff >= rows) begin
            ctl_in.last = 1'b1;
            count_in    = '0;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end else if (advance) begin
         ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         count_ff <= '0;
      end else begin
         ctl_ff   <= ctl_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hrow_ff <= hrow_in;
      end
   end

   assign ctl  = ctl_ff;
   assign hrow = hrow_ff;

endmodule

/* rtl/bsp_vstage.sv */
module bsp_vstage (
   input  logic                           clock,
   input  logic                           reset,
   input  bsp_pkg::ctl_type               ctl,
   input  bsp_pkg::row_type               hrow,
   input  logic [bsp_pkg::PHASE_W-1:0]    y_offset,
   output logic                           advance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bsp_pkg::rsp_type               rsp_payload
);

   bsp_pkg::row_type   prev_ff;
   bsp_pkg::row_type   vrow;
   bsp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   // a first row only refreshes the stored row, so it never waits on the output
   assign advance = ctl.valid && (ctl.first || !rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < bsp_pkg::ROW_WIDTH; i++) begin
         vrow[i] = bsp_pkg::tap2(prev_ff[i], hrow[i], y_offset);
      end
   end

   always_comb begin
      rsp_in.out0     = vrow[0];
      rsp_in.out1     = vrow[1];
      rsp_in.out2     = vrow[2];
      rsp_in.out3     = vrow[3];
      rsp_in.out4     = vrow[4];
      rsp_in.out5     = vrow[5];
      rsp_in.out6     = vrow[6];
      rsp_in.out7     = vrow[7];
      rsp_in.last_row = ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && !ctl.first) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_ff <= hrow;
      end
      if (advance && !ctl.first) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/bilinear_subpel_predict_8wide.sv */
// a request passes two register stages, the horizontal stage and then the result register
// throughput: one request per cycle unless rsp stalls; stage 1 waits for stage 2
// the first row of a block gives no result; each later row gives one
// reset: synchronous, active high; clears the row counter and both stage valids,
// sets x_offset and y_offset to 0 and block_rows to 8
module bilinear_subpel_predict_8wide (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: one source row of ROW_WIDTH+1 pixels
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bsp_pkg::req_type                  req_payload,
   // result channel: one predicted row
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bsp_pkg::rsp_type                  rsp_payload,
   // register write port
   input  logic                              csr_write_en,
   input  logic [bsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bsp_pkg::PHASE_W-1:0] x_offset_ff;
   logic [bsp_pkg::PHASE_W-1:0] y_offset_ff;
   logic [bsp_pkg::ROWS_W-1:0]  block_rows_ff;

   bsp_pkg::ctl_type            ctl;
   bsp_pkg::row_type            hrow;
   logic                        advance;

   // config registers, to be written only while the pipeline is drained (not enforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff   <= '0;
         y_offset_ff   <= '0;
         block_rows_ff <= bsp_pkg::BLOCK_ROWS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bsp_pkg::CSR_X_OFFSET:   x_offset_ff   <= csr_wdata[bsp_pkg::PHASE_W-1:0];
            bsp_pkg::CSR_Y_OFFSET:   y_offset_ff   <= csr_wdata[bsp_pkg::PHASE_W-1:0];
            bsp_pkg::CSR_BLOCK_ROWS: block_rows_ff <= csr_wdata;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // stage 1: horizontal taps and row counting, registered
   bsp_hstage u_hstage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .x_offset    (x_offset_ff),
      .block_rows  (block_rows_ff),
      .advance     (advance),
      .ctl         (ctl),
      .hrow        (hrow)
   );

   // stage 2: vertical taps against the stored row, into the result register
   bsp_vstage u_vstage (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .hrow        (hrow),
      .y_offset    (y_offset_ff),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/bilinear_subpel_predict_8wide_tb.sv */
module bilinear_subpel_predict_8wide_tb;

   localparam int REQ_W       = $bits(bsp_pkg::req_type);
   localparam int RSP_W       = $bits(bsp_pkg::rsp_type);
   localparam int ITEM_TARGET = 600;
   localparam int CALM_ITEMS  = 60;    // tail of the run with no idling on either side
   localparam int SETTLE      = 4;     // two register stages, with margin
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up

   // kinds of source rows the stimulus builds
   typedef enum int {
      ROW_ZERO,
      ROW_FULL,
      ROW_CHECKER,
      ROW_RAMP,
      ROW_FLAT,
      ROW_NOISE
   } row_kind_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   bsp_pkg::req_type               req_payload;
   logic                           rsp_valid;
   logic                           rsp_ready;
   bsp_pkg::rsp_type               rsp_payload;
   logic                           csr_write_en;
   logic [bsp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bsp_pkg::CSR_DATA_W-1:0] csr_wdata;

   bilinear_subpel_predict_8wide u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // source rows waiting for the driver, and predicted rows waiting for the block
   bsp_pkg::req_type pending_rows[$];
   bsp_pkg::rsp_type predicted_rows[$];

   // shadow of the block's registers, updated from the csr port itself
   logic [bsp_pkg::PHASE_W-1:0] x_phase = '0;
   logic [bsp_pkg::PHASE_W-1:0] y_phase = '0;
   logic [bsp_pkg::ROWS_W-1:0]  rows_per_block = bsp_pkg::BLOCK_ROWS_RESET;

   // shadow of the block's state: last horizontally filtered row and the row counter
   bsp_pkg::pixel_type          held_row [0:bsp_pkg::ROW_WIDTH-1];
   logic [bsp_pkg::ROWS_W-1:0]  rows_in_block = '0;

   int   rows_issued    = 0;
   int   rows_accepted  = 0;
   int   rows_checked   = 0;
   int   blocks_closed  = 0;
   int   settings_run   = 0;
   int   error_count    = 0;
   int   quiet_cycles   = 0;
   logic req_fired      = 1'b0;

   // idling control: odds out of 16 that a burst starts on a free cycle
   int   gap_odds   = 0;
   int   stall_odds = 0;
   logic calm       = 1'b0;
   int   req_gap    = 0;
   int   rsp_hold   = 0;

   // two-tap eighth-pel filter: taps 128-16p and 16p, round, shift by 7
   function automatic bsp_pkg::pixel_type two_tap_px(input bsp_pkg::pixel_type a,
                                                    input bsp_pkg::pixel_type b,
                                                    input logic [bsp_pkg::PHASE_W-1:0] phase);
      int w1;
      int v;
      w1 = 16 * int'(phase);
      v  = (int'(a) * (128 - w1) + int'(b) * w1 + 64) >>> 7;
      if (v > 255) v = 255;  // output range only, never reached
      return bsp_pkg::pixel_type'(v);
   endfunction

   // filter one source row; the first row of a block is only stored
   task automatic filter_row(input bsp_pkg::req_type src_row);
      bsp_pkg::pixel_type          src [0:bsp_pkg::ROW_WIDTH];
      bsp_pkg::pixel_type          hrow [0:bsp_pkg::ROW_WIDTH-1];
      logic [RSP_W-1:0]            want_v;
      logic [bsp_pkg::ROWS_W-1:0]  rows;
      src  = '{src_row.pix0, src_row.pix1, src_row.pix2, src_row.pix3, src_row.pix4,
               src_row.pix5, src_row.pix6, src_row.pix7, src_row.pix8};
      for (int c = 0; c < bsp_pkg::ROW_WIDTH; c++)
         hrow[c] = two_tap_px(src[c], src[c+1], x_phase);
      // zero rows per block behaves as one
      rows = (rows_per_block == '0) ? bsp_pkg::ROWS_W'(1) : rows_per_block;
      if (rows_in_block == '0) begin
         held_row      = hrow;
         rows_in_block = bsp_pkg::ROWS_W'(1);
      end else begin
         want_v = '0;
         for (int c = 0; c < bsp_pkg::ROW_WIDTH; c++)
            want_v[RSP_W-1-8*c -: 8] = two_tap_px(held_row[c], hrow[c], y_phase);
         held_row = hrow;
         // a counter already at or past a lowered block size closes the block now
         if (rows_in_block >= rows) begin
            want_v[0]     = 1'b1;
            rows_in_block = '0;
         end else begin
            rows_in_block = rows_in_block + 1'b1;
         end
         predicted_rows.push_back(bsp_pkg::rsp_type'(want_v));
      end
   endtask

   task automatic log_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // compare one result row with the oldest prediction, field by field
   task automatic check_row(input bsp_pkg::rsp_type got);
      bsp_pkg::rsp_type want;
      logic [RSP_W-1:0] got_v;
      logic [RSP_W-1:0] want_v;
      if (predicted_rows.size() == 0) begin
         log_mismatch($sformatf("result row %0d arrived with nothing predicted",
                                rows_checked));
      end else begin
         want   = predicted_rows.pop_front();
         got_v  = got;
         want_v = want;
         for (int c = 0; c < bsp_pkg::ROW_WIDTH; c++) begin
            if (got_v[RSP_W-1-8*c -: 8] !== want_v[RSP_W-1-8*c -: 8])
               log_mismatch($sformatf("row %0d out%0d got %0d want %0d", rows_checked, c,
                                      got_v[RSP_W-1-8*c -: 8], want_v[RSP_W-1-8*c -: 8]));
         end
         if (got.last_row !== want.last_row)
            log_mismatch($sformatf("row %0d last_row got %b want %b", rows_checked,
                                   got.last_row, want.last_row));
         if (want.last_row) blocks_closed++;
      end
      rows_checked++;
   endtask

   // monitor: everything is sampled at the rising edge
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (csr_write_en) begin
            quiet_cycles = 0;
            case (csr_index)
               bsp_pkg::CSR_X_OFFSET:   x_phase        = csr_wdata[bsp_pkg::PHASE_W-1:0];
               bsp_pkg::CSR_Y_OFFSET:   y_phase        = csr_wdata[bsp_pkg::PHASE_W-1:0];
               bsp_pkg::CSR_BLOCK_ROWS: rows_per_block = csr_wdata[bsp_pkg::ROWS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            filter_row(req_payload);
            rows_accepted++;
            req_fired    = 1'b1;
            quiet_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            check_row(rsp_payload);
            quiet_cycles = 0;
         end
         // watchdog: nothing has moved for far longer than any legal stall
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d rows still predicted",
                     quiet_cycles, predicted_rows.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // request driver: changes at the falling edge, holds a row until it is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (!calm && gap_odds > 0 && $urandom_range(15) < gap_odds) begin
            // start an idle burst that includes this cycle
            req_valid <= 1'b0;
            req_gap   = $urandom_range(18, 1) - 1;
         end else if (pending_rows.size() != 0) begin
            req_valid   <= 1'b1;
            req_payload <= pending_rows.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (!calm && stall_odds > 0 && $urandom_range(15) < stall_odds) begin
         rsp_ready <= 1'b0;
         rsp_hold  = $urandom_range(18, 1) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic bsp_pkg::req_type make_row(input row_kind_type kind);
      logic [REQ_W-1:0]   v;
      bsp_pkg::pixel_type base;
      bsp_pkg::pixel_type step;
      logic               phase;
      base  = bsp_pkg::pixel_type'($urandom);
      step  = bsp_pkg::pixel_type'($urandom_range(40));
      phase = 1'($urandom);
      for (int c = 0; c <= bsp_pkg::ROW_WIDTH; c++) begin
         case (kind)
            ROW_ZERO:    v[REQ_W-1-8*c -: 8] = 8'h00;
            ROW_FULL:    v[REQ_W-1-8*c -: 8] = 8'hff;
            ROW_CHECKER: v[REQ_W-1-8*c -: 8] = ((c % 2) == phase) ? 8'hff : 8'h00;
            ROW_RAMP:    v[REQ_W-1-8*c -: 8] = base + bsp_pkg::pixel_type'(c) * step;
            ROW_FLAT:    v[REQ_W-1-8*c -: 8] = base;
            default:     v[REQ_W-1-8*c -: 8] = bsp_pkg::pixel_type'($urandom);
         endcase
      end
      return bsp_pkg::req_type'(v);
   endfunction

   // half noise, with flat areas, ramps and hard edges mixed in
   function automatic row_kind_type pick_kind();
      case ($urandom_range(9))
         0:       return ROW_ZERO;
         1:       return ROW_FULL;
         2:       return ROW_CHECKER;
         3:       return ROW_RAMP;
         4:       return ROW_FLAT;
         default: return ROW_NOISE;
      endcase
   endfunction

   // queue a row; pushes happen just after a rising edge, clear of the driver
   task automatic queue_row(input bsp_pkg::req_type r);
      pending_rows.push_back(r);
      rows_issued++;
   endtask

   // wait until every row is taken and every result is back, then let the pipe empty
   task automatic wait_drained();
      while (rows_accepted != rows_issued || predicted_rows.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write selected registers, one per cycle, only while the block is idle
   task automatic program_regs(input logic [2:0] sel,
                               input logic [bsp_pkg::CSR_DATA_W-1:0] xv,
                               input logic [bsp_pkg::CSR_DATA_W-1:0] yv,
                               input logic [bsp_pkg::CSR_DATA_W-1:0] rv);
      if (sel[0]) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= bsp_pkg::CSR_X_OFFSET;
         csr_wdata    <= xv;
      end
      if (sel[1]) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= bsp_pkg::CSR_Y_OFFSET;
         csr_wdata    <= yv;
      end
      if (sel[2]) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= bsp_pkg::CSR_BLOCK_ROWS;
         csr_wdata    <= rv;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_run++;
      @(posedge clock);
   endtask

   initial begin
      int                             phase_len;
      logic [2:0]                     sel;
      logic [bsp_pkg::CSR_DATA_W-1:0] rows_val;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = bsp_pkg::CSR_X_OFFSET;
      csr_wdata    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: both offsets zero, so a full block of plain copies
      queue_row(make_row(ROW_ZERO));
      queue_row(make_row(ROW_FULL));
      queue_row(make_row(ROW_CHECKER));
      queue_row(make_row(ROW_ZERO));
      queue_row(make_row(ROW_FULL));
      queue_row(make_row(ROW_RAMP));
      queue_row(make_row(ROW_FLAT));
      queue_row(make_row(ROW_NOISE));
      queue_row(make_row(ROW_CHECKER));
      wait_drained();

      // largest phases, one row per block, full-scale swings in both directions
      program_regs(3'b111, 4'd7, 4'd7, 4'd1);
      queue_row(make_row(ROW_FULL));
      queue_row(make_row(ROW_ZERO));
      queue_row(make_row(ROW_ZERO));
      queue_row(make_row(ROW_FULL));
      queue_row(make_row(ROW_CHECKER));
      queue_row(make_row(ROW_CHECKER));
      wait_drained();

      // zero rows per block behaves as one; top phase bit of the write is dropped
      program_regs(3'b111, 4'd11, 4'd13, 4'd0);
      queue_row(make_row(ROW_FULL));
      queue_row(make_row(ROW_CHECKER));
      queue_row(make_row(ROW_NOISE));
      queue_row(make_row(ROW_RAMP));
      wait_drained();

      // random part: settings change between phases, often in the middle of a block,
      // so the row counter may already be past a newly lowered block size
      while (rows_issued < ITEM_TARGET) begin
         calm = (rows_issued >= ITEM_TARGET - CALM_ITEMS);
         if (settings_run == 3) begin
            // make sure the longest block size gets a few full blocks early on
            sel       = 3'b111;
            rows_val  = 4'd15;
            phase_len = 40;
         end else begin
            sel = 3'($urandom_range(7, 1));
            case ($urandom_range(7))
               0:       rows_val = 4'd0;
               1:       rows_val = 4'd1;
               2:       rows_val = 4'd15;
               3:       rows_val = 4'd4;
               4, 5:    rows_val = 4'd8;
               default: rows_val = 4'($urandom_range(15));
            endcase
            phase_len = $urandom_range(48, 8);
         end
         program_regs(sel, 4'($urandom), 4'($urandom), rows_val);
         // some phases run flat out, others idle heavily on one or both sides
         gap_odds   = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
         stall_odds = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
         for (int n = 0; n < phase_len; n++)
            queue_row(make_row(pick_kind()));
         wait_drained();
      end

      $display("%0d source rows under %0d register settings, %0d predicted rows checked",
               rows_accepted, settings_run, rows_checked);
      $display("%0d blocks closed, %0d mismatches", blocks_closed, error_count);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
